// ----- hw/rtl/mris_pkg.sv -----
package mris_pkg;

    // Default build of the unit
    localparam int DEF_MAX_DIMS  = 4;
    localparam int DEF_ROW_BITS  = 32;
    localparam int DEF_SIZE_BITS = 16;

    // Configuration register map
    localparam int DIM_COUNT_BITS = 3;
    localparam int CFG_INDEX_BITS = 4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DIM_COUNT   = 4'd0,
        CFG_SCALAR_MASK = 4'd1,
        CFG_SIZE_BASE   = 4'd2
    } cfg_reg_t;

endpackage

// ----- hw/rtl/mixed_radix_index_split_unit.sv -----
// Channel | Direction | Content (lowest bits first)
// s_*     | in        | tdata: row
// m_*     | out       | tdata: index_dim0 .. index_dim(MAX_DIMS-1); tuser: out_of_range
// cfg_*   | in        | cfg_index selects the register, cfg_data is its new value
//
// Rows pass through an input register, the divider stages (128 at the default build)
// and an output register; one row is taken every cycle unless m_tready stalls the pipeline.
// Each divider stage produces one restoring-division bit for one dimension.
// Reset (aresetn low, synchronous) empties the pipeline and restores the registers.
// A stall on m_tready freezes the whole pipeline; s_tready drops only while a
// finished result waits.
module mixed_radix_index_split_unit #(
    parameter int MAX_DIMS  = mris_pkg::DEF_MAX_DIMS,
    parameter int ROW_BITS  = mris_pkg::DEF_ROW_BITS,
    parameter int SIZE_BITS = mris_pkg::DEF_SIZE_BITS,
    localparam int S_DATA_BITS = ((ROW_BITS + 7) / 8) * 8,
    localparam int M_DATA_BITS = ((MAX_DIMS * SIZE_BITS + 7) / 8) * 8,
    localparam int CFG_DATA_BITS = (SIZE_BITS > MAX_DIMS)
        ? ((SIZE_BITS > mris_pkg::DIM_COUNT_BITS) ? SIZE_BITS : mris_pkg::DIM_COUNT_BITS)
        : ((MAX_DIMS > mris_pkg::DIM_COUNT_BITS) ? MAX_DIMS : mris_pkg::DIM_COUNT_BITS)
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [S_DATA_BITS-1:0]                s_tdata,   // row
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [M_DATA_BITS-1:0]                m_tdata,   // index_dim0, index_dim1, ...
    output logic                                  m_tuser,   // out_of_range
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mris_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]              cfg_data
);

    localparam int NSTG = MAX_DIMS * ROW_BITS;

    // ---------------- configuration registers ----------------
    logic [mris_pkg::DIM_COUNT_BITS-1:0] dim_count_reg;
    logic [MAX_DIMS-1:0]                 scalar_mask_reg;
    logic [SIZE_BITS-1:0]                size_reg [MAX_DIMS];
    int                                  used;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_count_reg   <= '0;
            scalar_mask_reg <= '0;
            for (int d = 0; d < MAX_DIMS; d++) begin
                size_reg[d] <= SIZE_BITS'(1);
            end
        end else if (cfg_valid) begin
            if (cfg_index == mris_pkg::CFG_DIM_COUNT) begin
                dim_count_reg <= cfg_data[mris_pkg::DIM_COUNT_BITS-1:0];
            end
            if (cfg_index == mris_pkg::CFG_SCALAR_MASK) begin
                scalar_mask_reg <= cfg_data[MAX_DIMS-1:0];
            end
            for (int d = 0; d < MAX_DIMS; d++) begin
                if (cfg_index == mris_pkg::CFG_INDEX_BITS'(int'(mris_pkg::CFG_SIZE_BASE) + d))
                begin
                    size_reg[d] <= cfg_data[SIZE_BITS-1:0];
                end
            end
        end
    end

    // Clamp the dimension count to the build size
    always_comb begin
        used = (int'(dim_count_reg) > MAX_DIMS) ? MAX_DIMS : int'(dim_count_reg);
    end

    // ---------------- division pipeline ----------------
    // work holds dividend bits shifting out at the top and quotient bits
    // shifting in at the bottom; part is the running remainder.
    logic                 vld_reg  [NSTG+1];
    logic [ROW_BITS-1:0]  work_reg [NSTG+1];
    logic [SIZE_BITS-1:0] part_reg [NSTG+1];
    logic [SIZE_BITS-1:0] idx_reg  [NSTG+1][MAX_DIMS];
    logic                 oor_reg  [NSTG+1];

    logic                   out_vld_reg;
    logic [M_DATA_BITS-1:0] out_data_reg;
    logic                   out_oor_reg;
    logic                   advance;

    // Move everything whenever the output slot is free or being emptied
    assign advance  = !out_vld_reg || m_tready;
    assign s_tready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (advance) begin
            vld_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            work_reg[0] <= s_tdata[ROW_BITS-1:0];
            part_reg[0] <= '0;
            oor_reg[0]  <= 1'b0;
            for (int d = 0; d < MAX_DIMS; d++) begin
                idx_reg[0][d] <= '0;
            end
        end
    end

    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        // Least significant dimension first, dividend bits MSB first
        localparam int K = MAX_DIMS - 1 - s / ROW_BITS;
        localparam int B = s % ROW_BITS;

        logic                 active;
        logic [SIZE_BITS:0]   trial;
        logic                 ge;
        logic [SIZE_BITS:0]   diff;
        logic [ROW_BITS-1:0]  work_next;
        logic [SIZE_BITS-1:0] part_next;
        logic [SIZE_BITS-1:0] idx_next;
        logic                 oor_next;

        always_comb begin
            active    = (K < used) && !scalar_mask_reg[K];
            trial     = {part_reg[s], work_reg[s][ROW_BITS-1]};
            ge        = trial >= {1'b0, size_reg[K]};
            diff      = trial - {1'b0, size_reg[K]};
            work_next = work_reg[s];
            part_next = part_reg[s];
            idx_next  = idx_reg[s][K];
            oor_next  = oor_reg[s];
            if (active) begin
                if (size_reg[K] == '0) begin
                    // Zero extent: the product is zero, nothing fits
                    oor_next = 1'b1;
                end else begin
                    work_next = {work_reg[s][ROW_BITS-2:0], ge};
                    part_next = ge ? diff[SIZE_BITS-1:0] : trial[SIZE_BITS-1:0];
                    if (B == ROW_BITS - 1) begin
                        idx_next  = part_next;
                        part_next = '0;
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s+1] <= 1'b0;
            end else if (advance) begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                work_reg[s+1] <= work_next;
                part_reg[s+1] <= part_next;
                oor_reg[s+1]  <= oor_next;
                for (int d = 0; d < MAX_DIMS; d++) begin
                    idx_reg[s+1][d] <= (d == K) ? idx_next : idx_reg[s][d];
                end
            end
        end
    end

    // ---------------- output register ----------------
    // A quotient left over after the top dimension means the row was too large.
    logic                   final_oor;
    logic [M_DATA_BITS-1:0] final_data;

    always_comb begin
        final_oor  = oor_reg[NSTG] || (work_reg[NSTG] != '0);
        final_data = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            final_data[d*SIZE_BITS +: SIZE_BITS] = final_oor ? '0 : idx_reg[NSTG][d];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= vld_reg[NSTG];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= final_data;
            out_oor_reg  <= final_oor;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_oor_reg;

endmodule

// ----- hw/rtl/mris_checker.sv -----
module mris_props #(
    parameter int M_DATA_BITS = 64
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [M_DATA_BITS-1:0] m_tdata,
    input logic                   m_tuser
);

    // An out-of-range row carries all-zero indices
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("out_of_range result with nonzero indices");

    // An empty output slot never blocks the input
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Reset drains the result channel
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind mixed_radix_index_split_unit mris_props #(
    .M_DATA_BITS(M_DATA_BITS)
) u_mris_props (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
